// ===== src/swmm_pkg.sv =====
// Shared types and register codes for the sliding window minimum/maximum filter.
// Depends on nothing; imported by the top level.
package swmm_pkg;

   localparam int FIELD_WIDTH = 32;
   localparam int CSR_DATA_WIDTH = 7;

   typedef enum logic [0:0] {
      REG_WINDOW_SIZE = 1'b0,
      REG_FIND_MAX    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] sample;
      logic                          start_stream;
      logic                          end_of_stream;
   } req_payload_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] window_extreme;
      logic                          last_result;
   } rsp_payload_type;

endpackage

// ===== src/swmm_cell.sv =====
// One stage of the sample shift line with its deque membership bit.
// Standalone; instantiated in a row by the top level.
module swmm_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift_en,
   input  logic                          start,
   input  logic                          in_window,
   input  logic                          find_max,
   input  logic signed [VALUE_WIDTH-1:0] sample_value,
   input  logic                          prev_alive,
   input  logic signed [VALUE_WIDTH-1:0] prev_value,
   input  logic                          prefix_ok,
   output logic                          pass_out,
   output logic                          alive,
   output logic signed [VALUE_WIDTH-1:0] value
);

   logic                          alive_ff, alive_in;
   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic                          kept;
   logic                          dominated;
   logic                          kill;

   // Membership after start clearing and retirement, before popping.
   assign kept = prev_alive && !start && in_window;
   assign dominated = find_max ? (sample_value > prev_value) : (prev_value > sample_value);
   // A dead stage or a dominated member lets the pop reach further back in time.
   assign pass_out = !kept || dominated;
   assign kill = kept && dominated && prefix_ok;
   assign alive_in = kept && !kill;

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= 1'b0;
      end else if (shift_en) begin
         alive_ff <= alive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         value_ff <= prev_value;
      end
   end

   assign alive = alive_ff;
   assign value = value_ff;

endmodule

// ===== src/swmm_prefix.sv =====
// Log-depth prefix AND over the pass bits of the stage row.
// Standalone; used by the top level to decide how far back a pop reaches.
module swmm_prefix #(
   parameter int DEPTH = 64
) (
   input  logic [DEPTH-1:0] pass_in,
   output logic [DEPTH-1:0] prefix_out
);

   logic [DEPTH-1:0] incl;
   logic [DEPTH-1:0] prior;

   always_comb begin
      incl = pass_in;
      for (int stride = 1; stride < DEPTH; stride = stride * 2) begin
         prior = incl;
         for (int i = 0; i < DEPTH; i++) begin
            if (i >= stride) begin
               incl[i] = prior[i] & prior[i - stride];
            end
         end
      end
   end

   // Exclusive form: stage j sees the AND of all younger stages.
   assign prefix_out = {incl[DEPTH-2:0], 1'b1};

endmodule

// ===== src/swmm_select.sv =====
// Selection tree returning the value of the oldest live stage.
// Standalone; reads the registered stage row of the top level.
module swmm_select #(
   parameter int DEPTH = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic [DEPTH-1:0]       alive,
   input  logic [VALUE_WIDTH-1:0] values [DEPTH],
   output logic [VALUE_WIDTH-1:0] oldest_value
);

   localparam int LEVELS = $clog2(DEPTH);
   localparam int LEAVES = 1 << LEVELS;

   logic [LEAVES-1:0]      found [LEVELS+1];
   logic [VALUE_WIDTH-1:0] picked [LEVELS+1][LEAVES];

   always_comb begin
      for (int l = 0; l <= LEVELS; l++) begin
         found[l] = '0;
         for (int i = 0; i < LEAVES; i++) begin
            picked[l][i] = '0;
         end
      end
      for (int i = 0; i < DEPTH; i++) begin
         found[0][i] = alive[i];
         picked[0][i] = values[i];
      end
      // Each node prefers its older (higher index) half when that half holds a member.
      for (int l = 0; l < LEVELS; l++) begin
         for (int i = 0; i < (LEAVES >> (l + 1)); i++) begin
            found[l+1][i] = found[l][2*i] | found[l][2*i+1];
            picked[l+1][i] = found[l][2*i+1] ? picked[l][2*i+1] : picked[l][2*i];
         end
      end
   end

   assign oldest_value = picked[LEVELS][0];

endmodule

// ===== src/sliding_window_min_max.sv =====
// Top level of the streaming sliding window minimum/maximum filter.
// Depends on swmm_pkg, swmm_cell, swmm_prefix and swmm_select.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   req_payload_type (sample, start, end)
//   rsp_      out        rsp_valid/rsp_ready   rsp_payload_type (extreme, last marker)
//   csr_      in         csr_we                csr_index, csr_wdata
//
// One transaction is accepted per cycle while req_ready is high. An accepted sample
// is registered in the stage row, the combinational oldest-member selection tree
// reads that row, and the result is registered in the output register.
// Reset is synchronous and clears only control state; stored samples need none.
// A stalled output holds one result, and one more waits in the stage row, before
// req_ready falls.
//
// The deque is kept as a shift line of the last WINDOW_MAX samples. Every stage
// carries a membership bit. On each accepted sample the whole row moves one
// stage older, the new sample enters stage zero as a member, stages that are
// older than the window lose membership, and then the members dominated by the
// new sample drop out, starting from the youngest and stopping at the first
// member that survives. That stopping rule is a prefix AND across the row,
// built as a log-depth network. The front of the deque is the oldest member.
module sliding_window_min_max
   import swmm_pkg::*;
#(
   parameter int WINDOW_MAX = 64,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_we,
   input  csr_index_type             csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   // Stored value width: sample bits above SAMPLE_WIDTH carry no information.
   localparam int VALUE_WIDTH = (SAMPLE_WIDTH < FIELD_WIDTH) ? SAMPLE_WIDTH : FIELD_WIDTH;
   localparam int FILL_WIDTH = $clog2(WINDOW_MAX + 1);
   localparam int K_WIDTH = (FILL_WIDTH > CSR_DATA_WIDTH) ? FILL_WIDTH : CSR_DATA_WIDTH;
   localparam logic [K_WIDTH-1:0] K_MAX = K_WIDTH'(WINDOW_MAX);
   localparam logic [FILL_WIDTH-1:0] FILL_FULL = FILL_WIDTH'(WINDOW_MAX);

   // Configuration registers.
   logic [CSR_DATA_WIDTH-1:0] window_size_ff;
   logic                      find_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= CSR_DATA_WIDTH'(1);
         find_max_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_WINDOW_SIZE: window_size_ff <= csr_wdata;
            REG_FIND_MAX:    find_max_ff <= csr_wdata[0];
            default:         window_size_ff <= window_size_ff;
         endcase
      end
   end

   // Effective window: zero acts as one, anything above the row length as the full row.
   logic [K_WIDTH-1:0] ws_wide;
   logic [K_WIDTH-1:0] k_eff;

   assign ws_wide = K_WIDTH'(window_size_ff);

   always_comb begin
      if (ws_wide == '0) begin
         k_eff = K_WIDTH'(1);
      end else if (ws_wide > K_MAX) begin
         k_eff = K_MAX;
      end else begin
         k_eff = ws_wide;
      end
   end

   // Handshake and output staging.
   logic                          accept;
   logic                          pend_ff, pend_in;
   logic                          pend_last_ff;
   logic                          move;
   logic                          rsp_valid_ff;
   rsp_payload_type               rsp_payload_ff;
   logic [FILL_WIDTH-1:0]         fill_ff, fill_in;
   logic                          start;
   logic signed [VALUE_WIDTH-1:0] sample_value;

   assign req_ready = !pend_ff || !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign move = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign start = req_payload.start_stream;
   assign sample_value = req_payload.sample[VALUE_WIDTH-1:0];

   // Samples seen since the stream began, saturating at the row length.
   always_comb begin
      if (start) begin
         fill_in = FILL_WIDTH'(1);
      end else if (fill_ff == FILL_FULL) begin
         fill_in = fill_ff;
      end else begin
         fill_in = fill_ff + FILL_WIDTH'(1);
      end
   end

   // A result is owed once the window has filled.
   assign pend_in = K_WIDTH'(fill_in) >= k_eff;

   // Stage row. Stage zero always takes the new sample as a member.
   logic [WINDOW_MAX-1:0]  cell_alive;
   logic [VALUE_WIDTH-1:0] cell_value [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]  cell_pass;
   logic [WINDOW_MAX-1:0]  cell_prefix;
   logic                   head_alive_ff;
   logic [VALUE_WIDTH-1:0] head_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_alive_ff <= 1'b0;
      end else if (accept) begin
         head_alive_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         head_value_ff <= sample_value;
      end
   end

   assign cell_alive[0] = head_alive_ff;
   assign cell_value[0] = head_value_ff;
   assign cell_pass[0] = 1'b1;

   for (genvar j = 1; j < WINDOW_MAX; j++) begin : g_stage
      logic in_window;
      logic signed [VALUE_WIDTH-1:0] prev_value;
      logic signed [VALUE_WIDTH-1:0] own_value;

      assign in_window = K_WIDTH'(j) < k_eff;
      assign prev_value = cell_value[j-1];
      assign cell_value[j] = own_value;

      swmm_cell #(
         .VALUE_WIDTH(VALUE_WIDTH)
      ) u_stage (
         .clock       (clock),
         .reset       (reset),
         .shift_en    (accept),
         .start       (start),
         .in_window   (in_window),
         .find_max    (find_max_ff),
         .sample_value(sample_value),
         .prev_alive  (cell_alive[j-1]),
         .prev_value  (prev_value),
         .prefix_ok   (cell_prefix[j]),
         .pass_out    (cell_pass[j]),
         .alive       (cell_alive[j]),
         .value       (own_value)
      );
   end

   swmm_prefix #(
      .DEPTH(WINDOW_MAX)
   ) u_prefix (
      .pass_in   (cell_pass),
      .prefix_out(cell_prefix)
   );

   logic [VALUE_WIDTH-1:0] front_value;

   swmm_select #(
      .DEPTH      (WINDOW_MAX),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_select (
      .alive       (cell_alive),
      .values      (cell_value),
      .oldest_value(front_value)
   );

   // Control registers: fill count, owed result and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            fill_ff <= fill_in;
            pend_ff <= pend_in;
         end else if (move) begin
            pend_ff <= 1'b0;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_last_ff <= req_payload.end_of_stream;
      end
      if (move) begin
         rsp_payload_ff.window_extreme <= FIELD_WIDTH'($signed(front_value));
         rsp_payload_ff.last_result <= pend_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   // The newest sample is always a member of the deque.
   a_head_member: assert property (@(posedge clock) disable iff (reset)
      accept |=> cell_alive[0])
      else $error("new sample did not join the deque");

   // A start clears every older member, so only the new sample remains.
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && start) |=> ($countones(cell_alive) == 1))
      else $error("start of stream left older deque members");

   // No new sample may enter while an owed result cannot reach the output register.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input taken while a result was still owed");

   // An accepted sample always counts toward the fill.
   a_fill_nonzero: assert property (@(posedge clock) disable iff (reset)
      accept |=> (fill_ff != '0))
      else $error("fill count empty after a sample");
`endif

endmodule

// ===== test/sliding_window_min_max_test.sv =====
// Self-checking testbench for the sliding window minimum/maximum filter.
// Depends on swmm_pkg and sliding_window_min_max; a built-in deque predictor
// supplies the expected result of every transaction that completes a window.
module sliding_window_min_max_test;
   import swmm_pkg::*;

   localparam int WINDOW_MAX = 64;
   localparam int SAMPLE_WIDTH = 32;
   localparam bit MODE_MIN = 1'b0;
   localparam bit MODE_MAX = 1'b1;
   // A comfortable margin for the block to settle.
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 200;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic signed [31:0] MOST_POSITIVE = 32'sh7FFFFFFF;
   localparam logic signed [31:0] MOST_NEGATIVE = 32'sh80000000;

   // Every input of the block starts at a known value.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_we = 1'b0;
   csr_index_type csr_index = REG_WINDOW_SIZE;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   sliding_window_min_max #(
      .WINDOW_MAX(WINDOW_MAX),
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // Deque predictor. It mirrors the register settings and keeps its own
   // monotonic deque of (value, position) pairs. Pointers run modulo twice
   // the depth so that a full and an empty deque can be told apart.
   // ------------------------------------------------------------------
   logic [6:0]        window_setting = 7'd1;
   bit                max_mode = MODE_MIN;
   logic signed [31:0] deque_value [WINDOW_MAX];
   logic [31:0]       deque_position [WINDOW_MAX];
   logic [6:0]        deque_head = '0;
   logic [6:0]        deque_tail = '0;
   logic [31:0]       stream_position = '0;
   int unsigned       stream_fill = 0;

   rsp_payload_type expected_extremes[$];

   // Returns 1 and fills result when the sample completes a full window.
   function automatic bit predict_window_extreme(input req_payload_type item,
                                                 output rsp_payload_type result);
      int unsigned span;
      logic [31:0] position;
      logic [6:0] probe;
      logic signed [31:0] value;
      logic signed [31:0] stored;
      bit scanning;
      bit dominated;

      // A window of zero behaves as one sample, anything past the depth as
      // the full depth.
      if (window_setting == 7'd0) begin
         span = 1;
      end else if (window_setting > WINDOW_MAX) begin
         span = WINDOW_MAX;
      end else begin
         span = window_setting;
      end
      value = item.sample;
      result = '0;

      if (item.start_stream) begin
         deque_head = '0;
         deque_tail = '0;
         stream_position = '0;
         stream_fill = 0;
      end
      position = stream_position;

      // Retire entries at the front that have left the window.
      scanning = 1'b1;
      while (scanning && (deque_tail - deque_head) != 7'd0) begin
         if (position - deque_position[deque_head[5:0]] >= span) begin
            deque_head = deque_head + 7'd1;
         end else begin
            scanning = 1'b0;
         end
      end

      // Drop entries at the back that the new sample dominates. An equal
      // entry stays, which does not change the reported value.
      scanning = 1'b1;
      while (scanning && (deque_tail - deque_head) != 7'd0) begin
         probe = deque_tail - 7'd1;
         stored = deque_value[probe[5:0]];
         dominated = max_mode ? (value > stored) : (stored > value);
         if (dominated) begin
            deque_tail = probe;
         end else begin
            scanning = 1'b0;
         end
      end

      deque_value[deque_tail[5:0]] = value;
      deque_position[deque_tail[5:0]] = position;
      deque_tail = deque_tail + 7'd1;
      stream_position = position + 32'd1;
      if (stream_fill < WINDOW_MAX) begin
         stream_fill++;
      end

      // Until the window has filled, the sample yields nothing and its end
      // marker is lost.
      if (stream_fill < span) begin
         return 1'b0;
      end
      result.window_extreme = deque_value[deque_head[5:0]];
      result.last_result = item.end_of_stream;
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Shared control between the stimulus, the receiver and the checker.
   // ------------------------------------------------------------------
   bit idle_on = 1'b1;
   int hold_requests = 0;
   int items_sent = 0;
   int failures = 0;
   int cycle_count = 0;

   // Sends one transaction. With idling on, a random gap may come first, and
   // then valid drops for the gap; otherwise valid stays high from the
   // previous transaction and only the payload changes.
   task automatic send_item(input logic signed [31:0] value, input bit first,
                            input bit last);
      req_payload_type item;
      rsp_payload_type result;
      int gap;
      item.sample = value;
      item.start_stream = first;
      item.end_of_stream = last;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      // The transaction was taken at this edge, so the predictor sees it now.
      if (predict_window_extreme(item, result)) begin
         expected_extremes.push_back(result);
      end
      items_sent++;
   endtask

   // Stops offering transactions, lets every expected result drain, and then
   // allows the pipeline to empty of samples that produce no result.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_extremes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the window size register and then the mode register; the block must be idle.
   task automatic set_config(input logic [6:0] size, input bit mode);
      csr_we <= 1'b1;
      csr_index <= REG_WINDOW_SIZE;
      csr_wdata <= size;
      @(posedge clock);
      window_setting = size;
      csr_index <= REG_FIND_MAX;
      csr_wdata <= {6'b0, mode};
      @(posedge clock);
      max_mode = mode;
      csr_we <= 1'b0;
   endtask

   // Half of the values are small so that ties and reordering are frequent, with
   // full range values and both extremes mixed in.
   function automatic logic signed [31:0] random_sample();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick <= 4) begin
         return $signed($urandom_range(0, 8)) - 4;
      end else if (pick <= 7) begin
         return $urandom;
      end else if (pick == 8) begin
         return MOST_POSITIVE;
      end
      return MOST_NEGATIVE;
   endfunction

   // One stream of random samples. A noisy stream also raises start and end
   // at random inside the stream.
   task automatic send_stream(input int length, input bit with_start, input bit noisy);
      bit first;
      bit last;
      for (int i = 0; i < length; i++) begin
         first = (with_start && i == 0) || (noisy && $urandom_range(0, 19) == 0);
         last = (i == length - 1) || (noisy && $urandom_range(0, 19) == 0);
         send_item(random_sample(), first, last);
      end
   endtask

   // ------------------------------------------------------------------
   // Test tasks, one per feature.
   // ------------------------------------------------------------------

   // Minimum mode over three samples: the extremes, a tie, an end marker
   // before the window is full (dropped), and an end without a start, after
   // which the next sample continues the old window.
   task automatic test_minimum_directed();
      set_config(7'd3, MODE_MIN);
      send_item(32'sd7, 1'b1, 1'b1);
      send_item(MOST_POSITIVE, 1'b0, 1'b0);
      send_item(MOST_NEGATIVE, 1'b0, 1'b0);
      send_item(32'sd5, 1'b0, 1'b0);
      send_item(32'sd5, 1'b0, 1'b0);
      send_item(32'sd5, 1'b0, 1'b0);
      send_item(-32'sd1, 1'b0, 1'b1);
      send_item(32'sd3, 1'b0, 1'b0);
   endtask

   // Maximum mode over two samples, with a tie at the most negative value and
   // a start raised in the middle of a stream.
   task automatic test_maximum_directed();
      wait_idle();
      set_config(7'd2, MODE_MAX);
      send_item(MOST_NEGATIVE, 1'b1, 1'b0);
      send_item(MOST_NEGATIVE, 1'b0, 1'b0);
      send_item(MOST_POSITIVE, 1'b0, 1'b0);
      send_item(32'sd0, 1'b0, 1'b0);
      send_item(-32'sd1, 1'b0, 1'b1);
      send_item(32'sd9, 1'b1, 1'b0);
      send_item(32'sd1, 1'b0, 1'b1);
   endtask

   // A window of zero, the largest setting of 127, exactly the depth, and one.
   task automatic test_window_limits();
      wait_idle();
      set_config(7'd0, MODE_MIN);
      send_item(32'sd4, 1'b1, 1'b1);
      send_item(-32'sd4, 1'b1, 1'b0);
      send_item(32'sd2, 1'b0, 1'b1);
      wait_idle();
      set_config(7'd127, MODE_MAX);
      send_stream(WINDOW_MAX + 4, 1'b1, 1'b0);
      wait_idle();
      set_config(7'd64, MODE_MIN);
      send_stream(WINDOW_MAX + 2, 1'b1, 1'b0);
      wait_idle();
      set_config(7'd1, MODE_MAX);
      send_stream(6, 1'b1, 1'b0);
   endtask

   // The stream runs on across register writes: the mode flips and the
   // window shrinks, grows and shrinks again, without a new start.
   task automatic test_changes_mid_stream();
      wait_idle();
      set_config(7'd4, MODE_MIN);
      send_stream(10, 1'b1, 1'b0);
      wait_idle();
      set_config(7'd2, MODE_MAX);
      send_stream(8, 1'b0, 1'b0);
      wait_idle();
      set_config(7'd6, MODE_MAX);
      send_stream(8, 1'b0, 1'b0);
      wait_idle();
      set_config(7'd3, MODE_MIN);
      send_stream(7, 1'b0, 1'b0);
   endtask

   // Random settings and streams. Most streams are long enough to fill their
   // window; some are too short to give any result, some continue without a
   // start, and a quarter carry stray start and end flags.
   task automatic test_random_streams();
      int target;
      int pick;
      int span;
      int length;
      logic [6:0] size;
      target = items_sent + 100;
      while (items_sent < target) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            size = 7'd0;
         end else if (pick == 1) begin
            size = 7'($urandom_range(WINDOW_MAX + 1, 127));
         end else if (pick <= 4) begin
            size = 7'($urandom_range(9, WINDOW_MAX));
         end else begin
            size = 7'($urandom_range(1, 8));
         end
         span = (size == 0) ? 1 : ((size > WINDOW_MAX) ? WINDOW_MAX : size);
         wait_idle();
         set_config(size, $urandom_range(0, 1) == 1);
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 5) == 0) begin
               length = $urandom_range(1, span);
            end else begin
               length = span + $urandom_range(0, 12);
            end
            send_stream(length, $urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0);
         end
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering, so the block fills and has to drop req_ready.
   task automatic test_output_stall();
      wait_idle();
      set_config(7'd1, MODE_MIN);
      hold_requests++;
      send_stream(40, 1'b1, 1'b0);
   endtask

   // Back-to-back transactions on both sides with no idling at all.
   task automatic test_full_rate();
      wait_idle();
      idle_on = 1'b0;
      set_config(7'd3, MODE_MAX);
      send_stream(60, 1'b1, 1'b0);
      wait_idle();
      set_config(7'd5, MODE_MIN);
      send_stream(50, 1'b1, 1'b1);
   endtask

   // ------------------------------------------------------------------
   // Receiver. A requested hold-off is counted out here; otherwise, with
   // idling on, ready drops in random bursts.
   // ------------------------------------------------------------------
   int hold_served = 0;
   int hold_left = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Checker. Every result transaction is matched with the oldest expected
   // one; the values read here are those that held at the edge.
   // ------------------------------------------------------------------
   rsp_payload_type expected_head;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_extremes.size() == 0) begin
            failures++;
            $display("%0t: unexpected result: expected none, actual extreme=%0d last=%0b",
                     $time, rsp_payload.window_extreme, rsp_payload.last_result);
         end else begin
            expected_head = expected_extremes.pop_front();
            if (rsp_payload.window_extreme !== expected_head.window_extreme ||
                rsp_payload.last_result !== expected_head.last_result) begin
               failures++;
               $display("%0t: result mismatch: expected extreme=%0d last=%0b, ",
                        $time, expected_head.window_extreme, expected_head.last_result,
                        "actual extreme=%0d last=%0b",
                        rsp_payload.window_extreme, rsp_payload.last_result);
            end
         end
      end
   end

   // A run that hangs ends here as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence of the run. Reset is held from the start and released once.
   // ------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_minimum_directed();
      test_maximum_directed();
      test_window_limits();
      test_changes_mid_stream();
      test_random_streams();
      test_output_stall();
      test_full_rate();
      // Drain, then give stray results time to show up.
      wait_idle();
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
